// ----- design/ekmf_pkg.sv -----
// shared types and constants for the edmonds-karp max-flow engine
// used by the controller, datapath and top level; depends on nothing
package ekmf_pkg;

    localparam int NODE_W         = 6;
    localparam int MAX_NODES      = 2 ** NODE_W;
    localparam int QPTR_W         = NODE_W + 1;
    localparam int CAP_IN_W       = 16;
    localparam int FLOW_W         = 24;
    localparam int NODE_COUNT_W   = 7;
    localparam int DEF_MAX_ARCS   = 512;
    localparam int DEF_CAP_BITS   = 16;
    localparam int IN_DATA_W      = 48;
    localparam int OUT_DATA_W     = 32;

    localparam logic [FLOW_W-1:0]       FLOW_MAX       = {FLOW_W{1'b1}};
    localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RST = NODE_COUNT_W'(MAX_NODES);

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_RUN   = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_RSVD  = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_ADD_FWD, S_ADD_REV, S_BFS_INIT, S_Q_CHECK, S_Q_READ,
        S_SCAN_START, S_SCAN, S_P1_PAR, S_P1_ARC, S_P1_MIN, S_P2_INIT, S_P2_PAR,
        S_P2_ARC, S_P2_SUB, S_P2_ADD, S_RESULT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_DECODE, OP_ADD_FWD, OP_ADD_REV, OP_BFS_INIT, OP_Q_READ,
        OP_SCAN_START, OP_SCAN, OP_PAR_RD, OP_ARC_RD, OP_MIN, OP_AUG2_INIT,
        OP_RES_SUB, OP_RES_ADD, OP_EMIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        t_action act;
        logic    ok;
        logic    src_eq_dst;
        logic    q_empty;
        logic    found;
        logic    scan_end;
        logic    from_is_src;
        logic    v_is_src;
        logic    out_free;
    } t_dp_stat;

endpackage

// ----- design/edmonds_karp_max_flow.sv -----
// top level of the edmonds-karp max-flow engine
// depends on ekmf_pkg, ekmf_ctrl, ekmf_dp (which uses ekmf_ram)
//
//  port group   dir  payload (low bit first)
//  s_axis       in   action[1:0] tail[7:2] head[13:8] capacity[29:14]
//                    source[35:30] sink[41:36], zero fill to 48
//  m_axis       out  status[1:0] flow_value[25:2], zero fill to 32
//  cfg          in   node_count[6:0], written whenever i_cfg_we is high
//
// add edge passes decode, forward and reverse arc writes, then the result
// register; clear passes decode only. a run does one bfs per augmenting
// path; each bfs reads every arc per dequeued node (one-read arc store),
// then walks each path arc twice, to find and to push the bottleneck
// reset clears arc count, visited bits and handshake state; no clearing pass
// input is taken only in idle; a stalled result waits in the output register
// while the next beat is accepted and worked on
module edmonds_karp_max_flow
    import ekmf_pkg::*;
#(
    parameter int MAX_ARCS = DEF_MAX_ARCS,
    parameter int CAP_BITS = DEF_CAP_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // input item beats
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    input  logic [IN_DATA_W-1:0]    i_s_tdata,  // action, tail_node, head_node,
                                                // capacity, source_node, sink_node
    // result beats
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    output logic [OUT_DATA_W-1:0]   o_m_tdata,  // status, flow_value
    // node count register
    input  logic                    i_cfg_we,
    input  logic [NODE_COUNT_W-1:0] i_cfg_wdata
);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     idle;
    logic     in_fire;

    // accept only when the controller sits idle
    assign o_s_tready = idle;
    assign in_fire    = i_s_tvalid && idle;

    ekmf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_fire(in_fire),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_idle   (idle)
    );

    ekmf_dp #(
        .MAX_ARCS(MAX_ARCS),
        .CAP_BITS(CAP_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in_data  (i_s_tdata),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_stat     (stat)
    );

endmodule

// ----- design/ekmf_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
module ekmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/ekmf_ctrl.sv -----
// controller state machine of the max-flow engine
// depends on ekmf_pkg; drives datapath commands from datapath status
module ekmf_ctrl
    import ekmf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_fire,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_idle
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:       if (i_in_fire) n_state = S_DECODE;
            S_DECODE: begin
                if (i_stat.act == ACT_ADD && i_stat.ok) begin
                    n_state = S_ADD_FWD;
                end else if (i_stat.act == ACT_RUN && i_stat.ok && !i_stat.src_eq_dst) begin
                    n_state = S_BFS_INIT;
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_ADD_FWD:    n_state = S_ADD_REV;
            S_ADD_REV:    n_state = S_RESULT;
            S_BFS_INIT:   n_state = S_Q_CHECK;
            S_Q_CHECK:    n_state = i_stat.q_empty ? S_RESULT : S_Q_READ;
            S_Q_READ:     n_state = S_SCAN_START;
            S_SCAN_START: n_state = S_SCAN;
            S_SCAN: begin
                if (i_stat.found) begin
                    n_state = S_P1_PAR;
                end else if (i_stat.scan_end) begin
                    n_state = S_Q_CHECK;
                end
            end
            S_P1_PAR:     n_state = S_P1_ARC;
            S_P1_ARC:     n_state = S_P1_MIN;
            S_P1_MIN:     n_state = i_stat.from_is_src ? S_P2_INIT : S_P1_PAR;
            S_P2_INIT:    n_state = S_P2_PAR;
            S_P2_PAR:     n_state = S_P2_ARC;
            S_P2_ARC:     n_state = S_P2_SUB;
            S_P2_SUB:     n_state = S_P2_ADD;
            S_P2_ADD:     n_state = i_stat.v_is_src ? S_BFS_INIT : S_P2_PAR;
            S_RESULT:     if (i_stat.out_free) n_state = S_IDLE;
            default:      n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd.op = OP_NONE;
        o_idle   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_idle   = 1'b1;
                o_cmd.op = i_in_fire ? OP_LOAD : OP_NONE;
            end
            S_DECODE:     o_cmd.op = OP_DECODE;
            S_ADD_FWD:    o_cmd.op = OP_ADD_FWD;
            S_ADD_REV:    o_cmd.op = OP_ADD_REV;
            S_BFS_INIT:   o_cmd.op = OP_BFS_INIT;
            S_Q_CHECK:    o_cmd.op = OP_NONE;
            S_Q_READ:     o_cmd.op = OP_Q_READ;
            S_SCAN_START: o_cmd.op = OP_SCAN_START;
            S_SCAN:       o_cmd.op = OP_SCAN;
            S_P1_PAR:     o_cmd.op = OP_PAR_RD;
            S_P1_ARC:     o_cmd.op = OP_ARC_RD;
            S_P1_MIN:     o_cmd.op = OP_MIN;
            S_P2_INIT:    o_cmd.op = OP_AUG2_INIT;
            S_P2_PAR:     o_cmd.op = OP_PAR_RD;
            S_P2_ARC:     o_cmd.op = OP_ARC_RD;
            S_P2_SUB:     o_cmd.op = OP_RES_SUB;
            S_P2_ADD:     o_cmd.op = OP_RES_ADD;
            S_RESULT:     o_cmd.op = OP_EMIT;
            default:      o_cmd.op = OP_NONE;
        endcase
    end

endmodule

// ----- design/ekmf_dp.sv -----
// datapath of the max-flow engine: arc store, bfs queue, parents, visited, flow sum
// depends on ekmf_pkg and ekmf_ram
module ekmf_dp
    import ekmf_pkg::*;
#(
    parameter int MAX_ARCS = DEF_MAX_ARCS,
    parameter int CAP_BITS = DEF_CAP_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    input  logic                    i_cfg_we,
    input  logic [NODE_COUNT_W-1:0] i_cfg_wdata,
    input  logic [IN_DATA_W-1:0]    i_in_data,
    input  logic                    i_m_tready,
    output logic                    o_m_tvalid,
    output logic [OUT_DATA_W-1:0]   o_m_tdata,
    output t_dp_stat                o_stat
);

    localparam int AW       = $clog2(MAX_ARCS);
    localparam int CW       = $clog2(MAX_ARCS + 1);
    localparam int RW       = CAP_BITS + 1;
    localparam int CAP_KEEP = (CAP_BITS < CAP_IN_W) ? CAP_BITS : CAP_IN_W;
    localparam int SUM_W    = RW + FLOW_W + 1;

    // latched item
    t_action                 r_act;
    logic [NODE_W-1:0]       r_tail, r_head, r_src, r_dst;
    logic [CAP_IN_W-1:0]     r_cap;
    logic [NODE_COUNT_W-1:0] r_node_count;
    logic [CW-1:0]           r_arc_count;
    t_status                 r_status;
    logic [FLOW_W-1:0]       r_total;

    // search state
    logic [MAX_NODES-1:0]    r_visited;
    logic [QPTR_W-1:0]       r_qhead, r_qtail;
    logic [NODE_W-1:0]       r_u, r_v;
    logic [CW-1:0]           r_scan_addr;
    logic                    r_scan_vld;
    logic [AW-1:0]           r_eval_addr, r_arc;
    logic [RW-1:0]           r_bneck;

    // output register
    logic                    r_out_valid;
    t_status                 r_out_status;
    logic [FLOW_W-1:0]       r_out_flow;

    // ram ports
    logic                    ft_we, res_we, par_we, q_we;
    logic [AW-1:0]           arc_waddr, arc_raddr;
    logic [2*NODE_W-1:0]     ft_wdata, ft_rdata;
    logic [RW-1:0]           res_wdata, res_rdata;
    logic [NODE_W-1:0]       par_waddr, q_wdata;
    logic [AW-1:0]           par_wdata, par_rdata;
    logic [NODE_W-1:0]       q_waddr, q_raddr, q_rdata;
    logic [NODE_W-1:0]       rd_from, rd_to;

    logic [NODE_COUNT_W-1:0] live_n;
    logic                    range_err, full_err, dec_ok;
    logic                    issue, hit, found, out_free;
    logic [SUM_W-1:0]        flow_sum;
    logic [RW-1:0]           cap_w;

    assign rd_from  = ft_rdata[NODE_W-1:0];
    assign rd_to    = ft_rdata[2*NODE_W-1:NODE_W];
    assign live_n   = (r_node_count > NODE_COUNT_RST) ? NODE_COUNT_RST : r_node_count;
    assign cap_w    = RW'(r_cap[CAP_KEEP-1:0]);
    assign full_err = ((CW + 1)'(r_arc_count) + (CW + 1)'(2)) > (CW + 1)'(MAX_ARCS);
    assign out_free = !r_out_valid || i_m_tready;

    always_comb begin
        range_err = 1'b0;
        dec_ok    = 1'b1;
        case (r_act)
            ACT_ADD: begin
                range_err = (NODE_COUNT_W'(r_tail) >= live_n) ||
                            (NODE_COUNT_W'(r_head) >= live_n);
                dec_ok    = !range_err && !full_err;
            end
            ACT_RUN: begin
                range_err = (NODE_COUNT_W'(r_src) >= live_n) ||
                            (NODE_COUNT_W'(r_dst) >= live_n);
                dec_ok    = !range_err;
            end
            default: begin
                range_err = 1'b0;
                dec_ok    = 1'b1;
            end
        endcase
    end

    // scan pipeline: each address is judged in the cycle after it is issued
    assign issue = (i_cmd.op == OP_SCAN) && (r_scan_addr < r_arc_count);
    assign hit   = (i_cmd.op == OP_SCAN) && r_scan_vld && (rd_from == r_u) &&
                   !r_visited[rd_to] && (res_rdata != '0);
    assign found = hit && (rd_to == r_dst);

    assign flow_sum = SUM_W'(r_total) + SUM_W'(r_bneck);

    // ram port muxing
    always_comb begin
        ft_we     = 1'b0;
        res_we    = 1'b0;
        arc_waddr = r_arc_count[AW-1:0];
        ft_wdata  = {r_head, r_tail};
        res_wdata = cap_w;
        arc_raddr = r_scan_addr[AW-1:0];
        par_we    = hit;
        par_waddr = rd_to;
        par_wdata = r_eval_addr;
        q_we      = hit && !found && (r_qtail < QPTR_W'(MAX_NODES));
        q_waddr   = r_qtail[NODE_W-1:0];
        q_wdata   = rd_to;
        q_raddr   = r_qhead[NODE_W-1:0];
        case (i_cmd.op)
            OP_ADD_FWD: begin
                ft_we  = 1'b1;
                res_we = 1'b1;
            end
            OP_ADD_REV: begin
                ft_we     = 1'b1;
                res_we    = 1'b1;
                arc_waddr = r_arc_count[AW-1:0] + AW'(1);
                ft_wdata  = {r_tail, r_head};
                res_wdata = '0;
            end
            OP_BFS_INIT: begin
                q_we    = 1'b1;
                q_waddr = '0;
                q_wdata = r_src;
            end
            OP_ARC_RD: arc_raddr = par_rdata;
            OP_RES_SUB: begin
                res_we    = 1'b1;
                arc_waddr = r_arc;
                res_wdata = res_rdata - r_bneck;
                arc_raddr = r_arc ^ AW'(1);
            end
            OP_RES_ADD: begin
                res_we    = 1'b1;
                arc_waddr = r_arc ^ AW'(1);
                res_wdata = res_rdata + r_bneck;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_COUNT_RST;
            r_arc_count  <= '0;
            r_visited    <= '0;
            r_out_valid  <= 1'b0;
            r_scan_vld   <= 1'b0;
            r_qhead      <= '0;
            r_qtail      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_node_count <= i_cfg_wdata;
            end
            if (r_out_valid && i_m_tready && (i_cmd.op != OP_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.op)
                OP_LOAD: begin
                    r_act   <= t_action'(i_in_data[1:0]);
                    r_tail  <= i_in_data[7:2];
                    r_head  <= i_in_data[13:8];
                    r_cap   <= i_in_data[29:14];
                    r_src   <= i_in_data[35:30];
                    r_dst   <= i_in_data[41:36];
                    r_total <= '0;
                end
                OP_DECODE: begin
                    r_status <= range_err ? ST_RANGE : (dec_ok ? ST_OK : ST_FULL);
                    if (r_act == ACT_CLEAR) begin
                        r_arc_count <= '0;
                    end
                end
                OP_ADD_REV: r_arc_count <= r_arc_count + CW'(2);
                OP_BFS_INIT: begin
                    r_visited <= MAX_NODES'(1) << r_src;
                    r_qhead   <= '0;
                    r_qtail   <= QPTR_W'(1);
                end
                OP_Q_READ: r_qhead <= r_qhead + QPTR_W'(1);
                OP_SCAN_START: begin
                    r_u         <= q_rdata;
                    r_scan_addr <= '0;
                    r_scan_vld  <= 1'b0;
                end
                OP_SCAN: begin
                    r_scan_vld  <= issue;
                    r_eval_addr <= r_scan_addr[AW-1:0];
                    if (issue) begin
                        r_scan_addr <= r_scan_addr + CW'(1);
                    end
                    if (hit) begin
                        r_visited[rd_to] <= 1'b1;
                    end
                    if (q_we) begin
                        r_qtail <= r_qtail + QPTR_W'(1);
                    end
                    if (found) begin
                        r_v     <= r_dst;
                        r_bneck <= '1;
                    end
                end
                OP_ARC_RD: r_arc <= par_rdata;
                OP_MIN: begin
                    if (res_rdata < r_bneck) begin
                        r_bneck <= res_rdata;
                    end
                    r_v <= rd_from;
                end
                OP_AUG2_INIT: r_v <= r_dst;
                OP_RES_SUB: r_v <= rd_from;
                OP_RES_ADD: begin
                    if (r_v == r_src) begin
                        r_total <= (flow_sum > SUM_W'(FLOW_MAX)) ? FLOW_MAX
                                                                 : flow_sum[FLOW_W-1:0];
                    end
                end
                OP_EMIT: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_status;
                        r_out_flow   <= r_total;
                    end
                end
                default: ;
            endcase
        end
    end

    ekmf_ram #(.WIDTH(2 * NODE_W), .DEPTH(MAX_ARCS)) u_ft_ram (
        .i_clk  (i_clk),
        .i_we   (ft_we),
        .i_waddr(arc_waddr),
        .i_wdata(ft_wdata),
        .i_raddr(arc_raddr),
        .o_rdata(ft_rdata)
    );

    ekmf_ram #(.WIDTH(RW), .DEPTH(MAX_ARCS)) u_res_ram (
        .i_clk  (i_clk),
        .i_we   (res_we),
        .i_waddr(arc_waddr),
        .i_wdata(res_wdata),
        .i_raddr(arc_raddr),
        .o_rdata(res_rdata)
    );

    ekmf_ram #(.WIDTH(AW), .DEPTH(MAX_NODES)) u_par_ram (
        .i_clk  (i_clk),
        .i_we   (par_we),
        .i_waddr(par_waddr),
        .i_wdata(par_wdata),
        .i_raddr(r_v),
        .o_rdata(par_rdata)
    );

    ekmf_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_q_ram (
        .i_clk  (i_clk),
        .i_we   (q_we),
        .i_waddr(q_waddr),
        .i_wdata(q_wdata),
        .i_raddr(q_raddr),
        .o_rdata(q_rdata)
    );

    assign o_stat.act         = r_act;
    assign o_stat.ok          = dec_ok;
    assign o_stat.src_eq_dst  = (r_src == r_dst);
    assign o_stat.q_empty     = (r_qhead == r_qtail);
    assign o_stat.found       = found;
    assign o_stat.scan_end    = !r_scan_vld && (r_scan_addr >= r_arc_count);
    assign o_stat.from_is_src = (rd_from == r_src);
    assign o_stat.v_is_src    = (r_v == r_src);
    assign o_stat.out_free    = out_free;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_DATA_W'({r_out_flow, r_out_status});

    a_arc_count_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_arc_count[0])
        else $error("arc count lost pair alignment");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_qtail <= QPTR_W'(MAX_NODES)) && (r_qhead <= r_qtail))
        else $error("search queue pointers out of order");

    a_hit_unvisited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hit |=> r_visited[$past(rd_to)])
        else $error("discovered node not marked visited");

endmodule
